// ===== rtl/pva_pkg.sv =====
package pva_pkg;

  // Table and field sizes
  localparam int NUM_VOICES_DEF = 24;
  localparam int MASK_W         = 24;
  localparam int VIU_W          = 5;
  localparam int VOICE_W        = 5;
  localparam int KEY_W          = 16;
  localparam int PRI_W          = 8;
  localparam int AGE_W          = 16;
  localparam int CFG_W          = 24;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 8;

  localparam logic [VIU_W-1:0] VIU_RESET = VIU_W'(24);
  localparam logic [KEY_W-1:0] KEY_MAX   = '1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_RESERVED_MASK = 1'b0,
    CFG_VOICES_IN_USE = 1'b1
  } cfg_idx_e;

  // Item kinds
  typedef enum logic [0:0] {
    OP_ALLOCATE = 1'b0,
    OP_UPDATE   = 1'b1
  } op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // One voice as seen by the compare unit
  typedef struct packed {
    logic             busy;
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
    logic [AGE_W-1:0] age;
  } cand_t;

  // Best steal candidate so far
  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } best_t;

  // Compare unit verdict
  typedef struct packed {
    logic free;
    logic better;
  } cmp_res_t;

endpackage

// ===== rtl/pva_cmp.sv =====
module pva_cmp (
  input  pva_pkg::cand_t    cand_i,
  input  pva_pkg::best_t    best_i,
  output pva_pkg::cmp_res_t res_o
);
  import pva_pkg::*;

  logic pri_lt, pri_eq, key_lt, key_eq, age_gt;

  // Priority first, then lowest key state, then strictly greatest age
  always_comb begin
    pri_lt = cand_i.pri < best_i.pri;
    pri_eq = cand_i.pri == best_i.pri;
    key_lt = cand_i.key < best_i.key;
    key_eq = cand_i.key == best_i.key;
    age_gt = cand_i.age > best_i.age;
    res_o.free   = !cand_i.busy && (cand_i.key == '0);
    res_o.better = pri_lt || (pri_eq && (key_lt || (key_eq && age_gt)));
  end

endmodule

// ===== rtl/priority_voice_allocator_top.sv =====
// An update goes from ST_IDLE through ST_FINISH to the result register; an allocate
//   first scans N voices in ST_SCAN, N being up to voices_in_use (capped at NumVoices),
//   fewer when an idle released voice is met early.
// Throughput: one item at a time; the single compare unit visits one voice per cycle.
// Reset: rst_ni clears the voice table, reserved_mask to 0 and voices_in_use to 24.
module priority_voice_allocator_top #(
  parameter int NumVoices = pva_pkg::NUM_VOICES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [pva_pkg::CFG_W-1:0]      cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pva_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // voice, busy_req, key_state, priority_req
  input  logic [0:0]                     s_axis_tuser,  // op
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pva_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // voice_index
  output logic [0:0]                     m_axis_tuser   // granted
);
  import pva_pkg::*;

  localparam int IW = (NumVoices > 1) ? $clog2(NumVoices) : 1;
  localparam int CW = $clog2(NumVoices + 1);
  localparam int LW = (CW > VIU_W) ? CW : VIU_W;

  // Input field unpacking
  logic [VOICE_W-1:0] in_voice;
  logic               in_busy;
  logic [KEY_W-1:0]   in_key;
  logic [PRI_W-1:0]   in_pri;
  op_e                in_op;

  assign in_voice = s_axis_tdata[VOICE_W-1:0];
  assign in_busy  = s_axis_tdata[VOICE_W];
  assign in_key   = s_axis_tdata[VOICE_W+KEY_W:VOICE_W+1];
  assign in_pri   = s_axis_tdata[VOICE_W+KEY_W+PRI_W:VOICE_W+KEY_W+1];
  assign in_op    = op_e'(s_axis_tuser[0]);

  // Configuration registers
  logic [MASK_W-1:0] mask_q;
  logic [VIU_W-1:0]  viu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      viu_q  <= VIU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RESERVED_MASK: mask_q <= cfg_data_i[MASK_W-1:0];
        CFG_VOICES_IN_USE: viu_q  <= cfg_data_i[VIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Voice table
  logic [NumVoices-1:0] busy_q;
  logic [KEY_W-1:0]     key_q [NumVoices];
  logic [PRI_W-1:0]     pri_q [NumVoices];
  logic [AGE_W-1:0]     age_q [NumVoices];

  // Sequencer registers
  state_e           state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    chosen_q, chosen_d;
  logic [PRI_W-1:0] req_pri_q, req_pri_d;
  best_t            best_q, best_d;
  logic             have_q, have_d;
  logic             grant_q, grant_d;

  // Result register
  logic             out_valid_q;
  logic             out_grant_q;
  logic [IW-1:0]    out_idx_q;

  // Scan length and reserved voices (voices past the mask are never reserved)
  logic [LW-1:0]                  limit;
  logic [NumVoices+MASK_W-1:0]    mask_ext;
  logic [NumVoices-1:0]           rsv;
  logic                           idx_last;

  always_comb begin
    limit    = (LW'(viu_q) < LW'(NumVoices)) ? LW'(viu_q) : LW'(NumVoices);
    mask_ext = {{NumVoices{1'b0}}, mask_q};
    rsv      = mask_ext[NumVoices-1:0];
    idx_last = (LW'(idx_q) + LW'(1)) >= limit;
  end

  // Shared compare unit, fed with the voice under the scan pointer
  cand_t    cand;
  cmp_res_t cmp_res;

  assign cand = '{busy: busy_q[idx_q], key: key_q[idx_q], pri: pri_q[idx_q],
                  age: age_q[idx_q]};

  pva_cmp u_cmp (
    .cand_i (cand),
    .best_i (best_q),
    .res_o  (cmp_res)
  );

  logic in_acc, out_free, load_out, upd_hit;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign upd_hit  = in_acc && (in_op == OP_UPDATE) && (LW'(in_voice) < LW'(NumVoices));

  // Next state and outputs
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    chosen_d      = chosen_q;
    req_pri_d     = req_pri_q;
    best_d        = best_q;
    have_d        = have_q;
    grant_d       = grant_q;
    load_out      = 1'b0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          idx_d     = '0;
          chosen_d  = '0;
          have_d    = 1'b0;
          grant_d   = 1'b0;
          req_pri_d = in_pri;
          best_d    = '{pri: in_pri, key: KEY_MAX, age: '0};
          if (in_op == OP_UPDATE || limit == '0) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!rsv[idx_q] && cmp_res.free) begin
          chosen_d = idx_q;
          grant_d  = 1'b1;
          state_d  = ST_FINISH;
        end else begin
          if (!rsv[idx_q] && cmp_res.better) begin
            best_d   = '{pri: cand.pri, key: cand.key, age: cand.age};
            chosen_d = idx_q;
            have_d   = 1'b1;
          end
          if (idx_last) begin
            grant_d = have_q || (!rsv[idx_q] && cmp_res.better);
            state_d = ST_FINISH;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      grant_q <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grant_q <= grant_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    chosen_q  <= chosen_d;
    req_pri_q <= req_pri_d;
    best_q    <= best_d;
  end

  // Table writes: updates on accept, aging and steal on a granted result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      for (int i = 0; i < NumVoices; i++) begin
        key_q[i] <= '0;
        pri_q[i] <= '0;
        age_q[i] <= '0;
      end
    end else if (upd_hit) begin
      busy_q[in_voice[IW-1:0]] <= in_busy;
      key_q[in_voice[IW-1:0]]  <= in_key;
      pri_q[in_voice[IW-1:0]]  <= in_pri;
    end else if (load_out && grant_q) begin
      // chosen voice restarts at age zero, other unreserved voices within the scan length age by one
      for (int i = 0; i < NumVoices; i++) begin
        if (IW'(i) == chosen_q) begin
          age_q[i] <= '0;
        end else if ((LW'(i) < limit) && !rsv[i]) begin
          age_q[i] <= age_q[i] + AGE_W'(1);
        end
      end
      pri_q[chosen_q] <= req_pri_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_grant_q <= grant_q;
      out_idx_q   <= grant_q ? chosen_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_grant_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_idx_q);

  // Checks
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (LW'(idx_q) < limit))
    else $error("scan pointer past scan length");

  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("voice index not zero without grant");

  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (LW'(out_idx_q) < limit))
    else $error("granted voice outside scan length");

  a_steal_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && grant_q) |=> (age_q[out_idx_q] == '0 && pri_q[out_idx_q] == $past(req_pri_q)))
    else $error("granted voice not reset to age zero with request priority");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pva_pkg::*;

  localparam int NV       = NUM_VOICES_DEF;
  localparam int N_PHASES = 6;
  localparam int PHASE_N  = 280;
  localparam int DRAIN_CY = 40;

  // Expected outcome of one item
  typedef struct packed {
    logic               granted;
    logic [VOICE_W-1:0] vidx;
  } grant_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // One row of the directed stimulus table
  typedef struct {
    row_kind_e          kind;
    op_e                op;
    logic [VOICE_W-1:0] voice;
    logic               busy;
    logic [KEY_W-1:0]   key;
    logic [PRI_W-1:0]   pri;
    cfg_idx_e           cfg_idx;
    logic [CFG_W-1:0]   cfg_val;
    bit                 typed;
    grant_t             want;
  } dir_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic                  cfg_idx_i     = 1'b0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // voice, busy_req, key_state, priority_req
  logic [0:0]            s_axis_tuser  = '0;  // op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // voice_index
  logic [0:0]            m_axis_tuser;        // granted

  // Shadow of the voice table and registers
  logic             tbl_busy [NV];
  logic [KEY_W-1:0] tbl_key  [NV];
  logic [PRI_W-1:0] tbl_pri  [NV];
  logic [AGE_W-1:0] tbl_age  [NV];
  logic [MASK_W-1:0] cur_mask = '0;
  logic [VIU_W-1:0]  cur_viu  = VIU_RESET;

  grant_t   grant_q[$];
  dir_row_t dir_rows[$];

  int err_cnt     = 0;
  int n_items     = 0;
  int n_alloc     = 0;
  int n_grants    = 0;
  int n_cfg       = 0;
  int tx_idle_pct = 7;
  int rx_idle_pct = 87;
  int hold_cycles = 0;

  priority_voice_allocator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Allocation model: update writes one voice, allocate scans and steals
  function automatic grant_t predict_grant(op_e op, logic [VOICE_W-1:0] v, logic b,
                                           logic [KEY_W-1:0] k, logic [PRI_W-1:0] p);
    grant_t           r;
    int               lim;
    int               pick;
    logic [PRI_W-1:0] bpri;
    logic [KEY_W-1:0] bkey;
    logic [AGE_W-1:0] bage;
    bit               hit;
    bit               matched;
    r = '0;
    if (op == OP_UPDATE) begin
      if (v < NV) begin
        tbl_busy[v] = b;
        tbl_key[v]  = k;
        tbl_pri[v]  = p;
      end
      return r;
    end
    lim     = (cur_viu < NV) ? int'(cur_viu) : NV;
    bpri    = p;
    bkey    = KEY_MAX;
    bage    = '0;
    hit     = 1'b0;
    matched = 1'b0;
    pick    = 0;
    for (int i = 0; i < lim; i++) begin
      if (cur_mask[i]) continue;
      // idle released voice wins outright
      if (!tbl_busy[i] && tbl_key[i] == '0) begin
        pick = i;
        hit  = 1'b1;
        break;
      end
      if (tbl_pri[i] < bpri) begin
        bpri = tbl_pri[i];
        bkey = tbl_key[i];
        bage = tbl_age[i];
        pick = i;
        matched = 1'b1;
      end else if (tbl_pri[i] == bpri) begin
        if (tbl_key[i] < bkey) begin
          bkey = tbl_key[i];
          bage = tbl_age[i];
          pick = i;
          matched = 1'b1;
        end else if (tbl_key[i] == bkey && tbl_age[i] > bage) begin
          bage = tbl_age[i];
          pick = i;
          matched = 1'b1;
        end
      end
    end
    if (hit || matched) begin
      for (int i = 0; i < lim; i++) begin
        if (!cur_mask[i]) tbl_age[i] = tbl_age[i] + 1'b1;
      end
      tbl_age[pick] = '0;
      tbl_pri[pick] = p;
      r.granted = 1'b1;
      r.vidx    = pick[VOICE_W-1:0];
    end
    return r;
  endfunction

  // Offer one item; record its expected outcome once the transaction completes
  task automatic send_item(op_e op, logic [VOICE_W-1:0] v, logic b, logic [KEY_W-1:0] k,
                           logic [PRI_W-1:0] p, bit typed, grant_t want);
    grant_t g;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, p, k, b, v};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    g = predict_grant(op, v, b, k, p);
    grant_q.push_back(typed ? want : g);
    n_items++;
    if (op == OP_ALLOCATE) n_alloc++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every outcome has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CY) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == CFG_RESERVED_MASK) cur_mask = val[MASK_W-1:0];
    else cur_viu = val[VIU_W-1:0];
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_item(op_e op, logic [VOICE_W-1:0] v, logic b, logic [KEY_W-1:0] k,
                          logic [PRI_W-1:0] p, bit typed, logic g, logic [VOICE_W-1:0] vi);
    dir_row_t r;
    r.kind         = ROW_ITEM;
    r.op           = op;
    r.voice        = v;
    r.busy         = b;
    r.key          = k;
    r.pri          = p;
    r.cfg_idx      = CFG_RESERVED_MASK;
    r.cfg_val      = '0;
    r.typed        = typed;
    r.want.granted = g;
    r.want.vidx    = vi;
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    dir_row_t r;
    r.kind    = ROW_CFG;
    r.op      = OP_ALLOCATE;
    r.voice   = '0;
    r.busy    = 1'b0;
    r.key     = '0;
    r.pri     = '0;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.typed   = 1'b0;
    r.want    = '0;
    dir_rows.push_back(r);
  endtask

  function automatic logic [PRI_W-1:0] pick_pri();
    case ($urandom_range(3))
      0:       return PRI_W'($urandom_range(3));
      1:       return '1;
      2:       return PRI_W'($urandom_range(255, 250));
      default: return PRI_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0:       return '0;
      1:       return KEY_W'($urandom_range(3));
      2:       return KEY_MAX;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Mostly meaningful traffic on live voices, some raw noise
  task automatic random_item();
    op_e              op;
    logic [VOICE_W-1:0] v;
    logic             b;
    grant_t           none;
    none = '0;
    if ($urandom_range(99) < 10) begin
      op = op_e'($urandom_range(1));
      send_item(op, VOICE_W'($urandom_range(31)), 1'($urandom_range(1)),
                KEY_W'($urandom), PRI_W'($urandom_range(255)), 1'b0, none);
    end else if ($urandom_range(99) < 45) begin
      send_item(OP_ALLOCATE, VOICE_W'($urandom_range(31)), 1'($urandom_range(1)),
                KEY_W'($urandom), pick_pri(), 1'b0, none);
    end else begin
      v = VOICE_W'($urandom_range(NV - 1));
      b = ($urandom_range(99) < 70);
      send_item(OP_UPDATE, v, b, pick_key(), pick_pri(), 1'b0, none);
    end
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles   = hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result, granted %0d voice_index %0d", $time,
                 m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        want = grant_q.pop_front();
        if (m_axis_tuser[0] !== want.granted) begin
          $display("%0t: granted mismatch, expected %0d, actual %0d", $time,
                   want.granted, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata !== {3'b000, want.vidx}) begin
          $display("%0t: voice_index mismatch, expected %0d, actual %0d", $time,
                   want.vidx, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser[0] === 1'b1) n_grants++;
      end
    end
  end

  // Main sequence
  initial begin
    logic [MASK_W-1:0] ph_mask;
    logic [VIU_W-1:0]  ph_viu;
    for (int i = 0; i < NV; i++) begin
      tbl_busy[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_pri[i]  = '0;
      tbl_age[i]  = '0;
    end

    // directed table
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd0, 1'b1, 1'b1, 5'd0);
    add_item(OP_UPDATE, 5'd0, 1'b1, 16'hFFFF, 8'd255, 1'b1, 1'b0, 5'd0);
    add_item(OP_UPDATE, 5'd31, 1'b1, 16'h1234, 8'd7, 1'b1, 1'b0, 5'd0);
    add_item(OP_UPDATE, 5'd24, 1'b0, 16'h0001, 8'd1, 1'b1, 1'b0, 5'd0);
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd128, 1'b0, 1'b0, 5'd0);
    add_cfg(CFG_RESERVED_MASK, 24'hFFFFFF);
    add_item(OP_ALLOCATE, 5'd31, 1'b1, 16'hFFFF, 8'd255, 1'b1, 1'b0, 5'd0);
    add_cfg(CFG_RESERVED_MASK, 24'h000000);
    // empty scan grants nothing
    add_cfg(CFG_VOICES_IN_USE, 24'd0);
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd255, 1'b1, 1'b0, 5'd0);
    add_cfg(CFG_VOICES_IN_USE, 24'd2);
    add_item(OP_UPDATE, 5'd1, 1'b1, 16'hFFFF, 8'd200, 1'b1, 1'b0, 5'd0);
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd255, 1'b0, 1'b0, 5'd0);
    // no candidate at or below the request
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd100, 1'b1, 1'b0, 5'd0);
    add_cfg(CFG_VOICES_IN_USE, 24'd1);
    add_item(OP_UPDATE, 5'd0, 1'b0, 16'h0001, 8'd0, 1'b1, 1'b0, 5'd0);
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd0, 1'b0, 1'b0, 5'd0);
    // equal priority, key all ones, age zero: tie never taken
    add_item(OP_UPDATE, 5'd0, 1'b1, 16'hFFFF, 8'd9, 1'b1, 1'b0, 5'd0);
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd9, 1'b1, 1'b0, 5'd0);
    // scan length above the table size
    add_cfg(CFG_VOICES_IN_USE, 24'd31);
    add_cfg(CFG_RESERVED_MASK, 24'hFFFFFE);
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd9, 1'b1, 1'b0, 5'd0);
    add_item(OP_ALLOCATE, 5'd0, 1'b0, 16'h0000, 8'd10, 1'b0, 1'b0, 5'd0);
    add_item(OP_UPDATE, 5'd23, 1'b1, 16'h8000, 8'd128, 1'b0, 1'b0, 5'd0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain_results();
        cfg_write(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
      end else begin
        send_item(dir_rows[r].op, dir_rows[r].voice, dir_rows[r].busy, dir_rows[r].key,
                  dir_rows[r].pri, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       begin ph_mask = '0;                     ph_viu = 5'd24; end
        1:       begin ph_mask = MASK_W'($urandom);      ph_viu = 5'd24; end
        2:       begin ph_mask = '1;                     ph_viu = 5'd24; end
        3:       begin ph_mask = 24'h0F0F0F;             ph_viu = 5'd1;  end
        4:       begin ph_mask = MASK_W'($urandom) & MASK_W'($urandom);
                       ph_viu = VIU_W'($urandom_range(24, 1)); end
        default: begin ph_mask = '0;                     ph_viu = 5'd12; end
      endcase
      if (ph < 2) begin
        tx_idle_pct = 7;
        rx_idle_pct = 87;
      end else if (ph < 4) begin
        tx_idle_pct = 87;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      drain_results();
      cfg_write(CFG_RESERVED_MASK, CFG_W'(ph_mask));
      cfg_write(CFG_VOICES_IN_USE, CFG_W'(ph_viu));
      for (int n = 0; n < PHASE_N; n++) begin
        // long receiver hold-off to back the block up
        if ((ph == 0 || ph == 4) && n == 100) hold_cycles = 400;
        random_item();
      end
    end

    drain_results();
    if (grant_q.size() != 0) err_cnt++;
    $display("covered %0d items (%0d allocations, %0d grants) over %0d register writes",
             n_items, n_alloc, n_grants, n_cfg);
    $display("%0d check failures", err_cnt);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", grant_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
